// File: src/rvie_pkg.sv
// ----------------------------------------------------------------------------
// rvie_pkg: shared types and constants of the register machine executor
// Opcodes, request and status codes, the buffered request and the execute
// decision that the execute logic hands to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rvie_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_REGS   = 5;
  localparam int REG_IDX_W  = 3;
  // Data RAM depth; a power of two, so an address wraps by dropping high bits
  localparam int RAM_DEPTH  = 1024;
  localparam int RAM_ADDR_W = $clog2(RAM_DEPTH);
  localparam int HOST_ADDR_W = 10;
  localparam int OP_LAST    = 20;

  typedef enum logic [4:0] {
    OP_STO = 5'd0,
    OP_RTM = 5'd1,
    OP_MTR = 5'd2,
    OP_RTR = 5'd3,
    OP_INC = 5'd4,
    OP_DEC = 5'd5,
    OP_LOA = 5'd6,
    OP_ADD = 5'd7,
    OP_SUB = 5'd8,
    OP_MUL = 5'd9,
    OP_EQU = 5'd10,
    OP_NEQ = 5'd11,
    OP_QRT = 5'd12,
    OP_JMP = 5'd13,
    OP_CJP = 5'd14,
    OP_JSB = 5'd15,
    OP_RET = 5'd16,
    OP_PRI = 5'd17,
    OP_PRC = 5'd18,
    OP_SCI = 5'd19,
    OP_SCC = 5'd20
  } op_t;

  typedef enum logic [1:0] {
    REQ_EXEC    = 2'd0,
    REQ_HOST_WR = 2'd1,
    REQ_HOST_RD = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_STOP = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef logic [NUM_REGS-1:0][WORD_W-1:0] regfile_t;

  // One buffered request
  typedef struct packed {
    logic [1:0]             req_type;
    logic [WORD_W-1:0]      opcode_word;
    logic [WORD_W-1:0]      arg_first;
    logic [WORD_W-1:0]      arg_second;
    logic [WORD_W-1:0]      arg_third;
    logic [WORD_W-1:0]      console_value;
    logic [HOST_ADDR_W-1:0] host_addr;
    logic [WORD_W-1:0]      host_data;
  } item_t;

  // Execute decision for the buffered request
  typedef struct packed {
    status_t               status;
    logic [WORD_W-1:0]     ip_next;
    logic                  reg_we;
    logic                  reg_from_ram;
    logic [REG_IDX_W-1:0]  reg_waddr;
    logic [WORD_W-1:0]     reg_wdata;
    logic                  regs_restore;
    logic                  shadow_save;
    logic [WORD_W-1:0]     ret_addr_next;
    logic                  ram_we;
    logic                  ram_rd;
    logic [RAM_ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  host_rd;
    logic                  print_valid;
    logic                  print_is_char;
    logic [WORD_W-1:0]     print_value;
  } exec_t;

  // Number of register operands an opcode checks
  function automatic logic [1:0] regs_used(op_t op);
    logic [1:0] n;
    case (op)
      OP_RTM, OP_MTR, OP_RTR, OP_CJP: n = 2'd2;
      OP_INC, OP_DEC, OP_LOA, OP_JMP, OP_JSB,
      OP_PRI, OP_PRC, OP_SCI, OP_SCC: n = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_EQU, OP_NEQ, OP_QRT: n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // True when a program word names an existing register
  function automatic logic idx_ok(logic [WORD_W-1:0] idx);
    return idx < WORD_W'(NUM_REGS);
  endfunction

endpackage

`default_nettype wire

// File: src/register_vm_instruction_executor.sv
// ----------------------------------------------------------------------------
// register_vm_instruction_executor: five-register 32-bit machine, one step
// Executes one instruction or one host RAM access per request and reports
// status, next instruction pointer, print data and read data.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid/in_stall carries the request type, the opcode
//   word with its three argument words, the console value and the host RAM
//   address and data. Result channel out_valid/out_stall returns one
//   result per request, in order.
//   A transfer lands in the request register; when the result slot is free
//   it executes and loads the result register. Requests that read the data
//   RAM (mtr, host read) first issue the registered RAM read, then finish.
//   Throughput is one request per cycle while out_stall stays low; a RAM
//   read holds the request register for its read phase, so the data RAM
//   read port limits the requests that read it.
//   While the result register is stalled the buffered request waits and
//   in_stall rises; a new request is taken in the same cycle that the
//   buffered one completes.
//   Reset clears the registers, shadow copy, instruction pointer, return
//   address and both valid flags. RAM contents are not cleared and must be
//   written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module register_vm_instruction_executor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] opcode_word,
  input  wire logic [31:0] arg_first,
  input  wire logic [31:0] arg_second,
  input  wire logic [31:0] arg_third,
  input  wire logic [31:0] console_value,
  input  wire logic [9:0]  host_addr,
  input  wire logic [31:0] host_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      next_ip,
  output logic             print_valid,
  output logic             print_is_char,
  output logic [31:0]      print_value,
  output logic [31:0]      read_data
);

  rvie_pkg::item_t                     s1_item;
  logic                                s1_valid;
  logic                                phase;
  rvie_pkg::regfile_t                  gp_regs;
  rvie_pkg::regfile_t                  shadow_regs;
  logic [rvie_pkg::WORD_W-1:0]         instr_ptr;
  logic [rvie_pkg::WORD_W-1:0]         return_addr;
  rvie_pkg::exec_t                     ex;
  logic [rvie_pkg::WORD_W-1:0]         ram_rdata;
  logic                                ram_re;
  logic                                ram_we;
  logic                                fire;
  logic                                out_free;

  // Execute logic
  rvie_exec u_exec (
    .item     (s1_item),
    .regs     (gp_regs),
    .ip       (instr_ptr),
    .ret_addr (return_addr),
    .ex       (ex)
  );

  // Data RAM
  rvie_ram #(
    .DATA_W (rvie_pkg::WORD_W),
    .DEPTH  (rvie_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ex.ram_addr),
    .wdata (ex.ram_wdata),
    .rdata (ram_rdata)
  );

  // Handshake: complete when operands are ready and the result slot is free
  assign out_free = !out_valid || !out_stall;
  assign fire     = s1_valid && (!ex.ram_rd || phase) && out_free;
  assign in_stall = s1_valid && !fire;
  assign ram_re   = s1_valid && ex.ram_rd && !phase;
  assign ram_we   = fire && ex.ram_we;

  // Request register and RAM read phase
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        phase <= 1'b0;
      end else if (ram_re) begin
        phase <= 1'b1;
      end
    end
  end

  // Capture request payload on transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.req_type      <= req_type;
      s1_item.opcode_word   <= opcode_word;
      s1_item.arg_first     <= arg_first;
      s1_item.arg_second    <= arg_second;
      s1_item.arg_third     <= arg_third;
      s1_item.console_value <= console_value;
      s1_item.host_addr     <= host_addr;
      s1_item.host_data     <= host_data;
    end
  end

  // Architectural state update on completion
  always_ff @(posedge clk) begin
    if (rst) begin
      gp_regs     <= '0;
      shadow_regs <= '0;
      instr_ptr   <= '0;
      return_addr <= '0;
    end else if (fire) begin
      instr_ptr <= ex.ip_next;
      if (ex.regs_restore) begin
        gp_regs <= shadow_regs;
      end else if (ex.reg_we) begin
        gp_regs[ex.reg_waddr] <= ex.reg_from_ram ? ram_rdata : ex.reg_wdata;
      end
      if (ex.shadow_save) begin
        shadow_regs <= gp_regs;
        return_addr <= ex.ret_addr_next;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      status        <= ex.status;
      next_ip       <= ex.ip_next;
      print_valid   <= ex.print_valid;
      print_is_char <= ex.print_is_char;
      print_value   <= ex.print_value;
      read_data     <= ex.host_rd ? ram_rdata : '0;
    end
  end

  // A RAM read leaves the request in place and sets the read phase
  a_read_holds: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (s1_valid && phase))
    else $error("RAM read issued without holding the request");

  // The read phase only exists with a buffered request
  a_phase_valid: assert property (@(posedge clk) disable iff (rst)
    phase |-> s1_valid)
    else $error("read phase set with no buffered request");

  // Every completion loads the result register
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("completed request produced no result");

  // Stop and invalid instructions leave the pointer alone
  a_bad_no_ip: assert property (@(posedge clk) disable iff (rst)
    (fire && ex.status != rvie_pkg::ST_OK) |=> $stable(instr_ptr))
    else $error("pointer changed on stop or invalid instruction");

  // Stop and invalid instructions write no state
  a_bad_no_write: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && ex.status != rvie_pkg::ST_OK) |->
      (!ex.reg_we && !ex.ram_we && !ex.shadow_save && !ex.regs_restore))
    else $error("state write on stop or invalid instruction");

endmodule

`default_nettype wire

// File: src/rvie_ram.sv
// ----------------------------------------------------------------------------
// rvie_ram: generic single-port RAM
// One write and one read per cycle, both at the same address; read data is
// registered and holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module rvie_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DATA_W-1:0]        wdata,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: src/rvie_exec.sv
// ----------------------------------------------------------------------------
// rvie_exec: decode and execute logic
// Checks the opcode and register operands of the buffered request and
// works out every state update and result field for it.
// ----------------------------------------------------------------------------
`default_nettype none

module rvie_exec (
  input  wire rvie_pkg::item_t                   item,
  input  wire rvie_pkg::regfile_t                regs,
  input  wire logic [rvie_pkg::WORD_W-1:0]       ip,
  input  wire logic [rvie_pkg::WORD_W-1:0]       ret_addr,
  output rvie_pkg::exec_t                        ex
);

  logic [rvie_pkg::WORD_W-1:0]   ra;
  logic [rvie_pkg::WORD_W-1:0]   rb;
  logic [rvie_pkg::WORD_W-1:0]   rc;
  logic [rvie_pkg::WORD_W-1:0]   prod;
  rvie_pkg::op_t                 op;
  logic [1:0]                    n_used;
  logic                          bad_idx;

  // Register read, zero for an index outside the file
  function automatic logic [rvie_pkg::WORD_W-1:0] reg_at(
    rvie_pkg::regfile_t r, logic [rvie_pkg::WORD_W-1:0] idx);
    logic [rvie_pkg::WORD_W-1:0] v;
    v = '0;
    if (rvie_pkg::idx_ok(idx)) begin
      v = r[idx[rvie_pkg::REG_IDX_W-1:0]];
    end
    return v;
  endfunction

  // Operand fetch and operand check
  assign ra      = reg_at(regs, item.arg_first);
  assign rb      = reg_at(regs, item.arg_second);
  assign rc      = reg_at(regs, item.arg_third);
  assign prod    = rb * rc;
  assign op      = rvie_pkg::op_t'(item.opcode_word[4:0]);
  assign n_used  = rvie_pkg::regs_used(op);
  assign bad_idx = (n_used >= 2'd1 && !rvie_pkg::idx_ok(item.arg_first))
                || (n_used >= 2'd2 && !rvie_pkg::idx_ok(item.arg_second))
                || (n_used >= 2'd3 && !rvie_pkg::idx_ok(item.arg_third));

  // Decide updates and result fields
  always_comb begin
    ex               = '0;
    ex.status        = rvie_pkg::ST_OK;
    ex.ip_next       = ip;
    ex.reg_waddr     = item.arg_first[rvie_pkg::REG_IDX_W-1:0];
    ex.ret_addr_next = ip + 32'd2;
    ex.ram_wdata     = rb;
    ex.ram_addr      = rvie_pkg::RAM_ADDR_W'(item.host_addr);
    case (item.req_type)
      rvie_pkg::REQ_HOST_WR: begin
        ex.ram_we    = 1'b1;
        ex.ram_wdata = item.host_data;
      end
      rvie_pkg::REQ_HOST_RD: begin
        ex.ram_rd  = 1'b1;
        ex.host_rd = 1'b1;
      end
      rvie_pkg::REQ_EXEC: begin
        if (item.opcode_word == '0) begin
          ex.status = rvie_pkg::ST_STOP;
        end else if (item.opcode_word > 32'(rvie_pkg::OP_LAST) || bad_idx) begin
          ex.status = rvie_pkg::ST_BAD;
        end else begin
          case (op)
            rvie_pkg::OP_RTM: begin
              ex.ram_we   = 1'b1;
              ex.ram_addr = rvie_pkg::RAM_ADDR_W'(ra);
              ex.ip_next  = ip + 32'd3;
            end
            rvie_pkg::OP_MTR: begin
              ex.ram_rd       = 1'b1;
              ex.ram_addr     = rvie_pkg::RAM_ADDR_W'(rb);
              ex.reg_we       = 1'b1;
              ex.reg_from_ram = 1'b1;
              ex.ip_next      = ip + 32'd3;
            end
            rvie_pkg::OP_RTR: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = rb;
              ex.ip_next   = ip + 32'd3;
            end
            rvie_pkg::OP_INC: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = ra + 32'd1;
              ex.ip_next   = ip + 32'd2;
            end
            rvie_pkg::OP_DEC: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = ra - 32'd1;
              ex.ip_next   = ip + 32'd2;
            end
            rvie_pkg::OP_LOA: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = item.arg_second;
              ex.ip_next   = ip + 32'd3;
            end
            rvie_pkg::OP_ADD: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = rb + rc;
              ex.ip_next   = ip + 32'd4;
            end
            rvie_pkg::OP_SUB: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = rb - rc;
              ex.ip_next   = ip + 32'd4;
            end
            rvie_pkg::OP_MUL: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = prod[rvie_pkg::WORD_W-1:0];
              ex.ip_next   = ip + 32'd4;
            end
            rvie_pkg::OP_EQU: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = 32'(rb == rc);
              ex.ip_next   = ip + 32'd4;
            end
            rvie_pkg::OP_NEQ: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = 32'(rb != rc);
              ex.ip_next   = ip + 32'd4;
            end
            rvie_pkg::OP_QRT: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = 32'(rb > rc);
              ex.ip_next   = ip + 32'd4;
            end
            rvie_pkg::OP_JMP: begin
              ex.ip_next = ra;
            end
            rvie_pkg::OP_CJP: begin
              ex.ip_next = (ra != '0) ? rb : ip + 32'd3;
            end
            rvie_pkg::OP_JSB: begin
              ex.shadow_save = 1'b1;
              ex.ip_next     = ra;
            end
            rvie_pkg::OP_RET: begin
              ex.regs_restore = 1'b1;
              ex.ip_next      = ret_addr;
            end
            rvie_pkg::OP_PRI: begin
              ex.print_valid = 1'b1;
              ex.print_value = ra;
              ex.ip_next     = ip + 32'd2;
            end
            rvie_pkg::OP_PRC: begin
              ex.print_valid   = 1'b1;
              ex.print_is_char = 1'b1;
              ex.print_value   = ra;
              ex.ip_next       = ip + 32'd2;
            end
            rvie_pkg::OP_SCI: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = item.console_value;
              ex.ip_next   = ip + 32'd2;
            end
            rvie_pkg::OP_SCC: begin
              ex.reg_we    = 1'b1;
              ex.reg_wdata = {24'd0, item.console_value[7:0]};
              ex.ip_next   = ip + 32'd2;
            end
            default: begin
              ex.status = rvie_pkg::ST_BAD;
            end
          endcase
        end
      end
      default: begin
        ex.status = rvie_pkg::ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire
